>>> hw/rtl/arc_odometry_pose_tracker_core_assert.svh
// Assertion macros for the pose tracker core.
`ifndef ARC_ODOMETRY_POSE_TRACKER_CORE_ASSERT_SVH
`define ARC_ODOMETRY_POSE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off during rst.
`define AOPT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define AOPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/aopt_pkg.sv
// Shared types, constants and helper functions for the pose tracker.
package aopt_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int OP_W   = 40;          // serial multiplier / divider operand width
  localparam int PROD_W = 2 * OP_W;    // product width
  localparam int WIDE_W = PROD_W + 2;  // sums of products
  localparam int CW     = 36;          // CORDIC datapath width
  localparam int ANG_W  = 22;          // reduced Q.17 angle
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 2;

  typedef logic signed [OP_W-1:0]   aopt_op_t;
  typedef logic signed [PROD_W-1:0] aopt_prod_t;
  typedef logic signed [WIDE_W-1:0] aopt_wide_t;
  typedef logic signed [CW-1:0]     aopt_cw_t;
  typedef logic signed [ANG_W-1:0]  aopt_ang_t;

  localparam logic [IDX_W-1:0] REG_WHEEL_RADIUS        = 2'd0;
  localparam logic [IDX_W-1:0] REG_LATERAL_OFFSET      = 2'd1;
  localparam logic [IDX_W-1:0] REG_LONGITUDINAL_OFFSET = 2'd2;

  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_SET_POSE = 1'b1;

  localparam logic [CFG_W-1:0] WHEEL_RADIUS_RST = 24'd180224;

  localparam aopt_op_t  DEG2RAD_Q32 = 40'sd749613;  // pi * 2^32 / 18000
  localparam aopt_ang_t TWO_PI_Q17  = 22'sd823550;
  localparam aopt_ang_t PI_Q17      = 22'sd411775;
  localparam aopt_ang_t HALF_PI_Q17 = 22'sd205887;
  localparam aopt_cw_t  CORDIC_GAIN = 36'sd652032874;

  localparam aopt_wide_t MAX32 = 82'sd2147483647;
  localparam aopt_wide_t MIN32 = -82'sd2147483648;

  function automatic aopt_cw_t atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 36'sd843314857;
      5'd1:  return 36'sd497837829;
      5'd2:  return 36'sd263043837;
      5'd3:  return 36'sd133525159;
      5'd4:  return 36'sd67021687;
      5'd5:  return 36'sd33543516;
      5'd6:  return 36'sd16775851;
      5'd7:  return 36'sd8388437;
      5'd8:  return 36'sd4194283;
      5'd9:  return 36'sd2097149;
      5'd10: return 36'sd1048576;
      5'd11: return 36'sd524288;
      5'd12: return 36'sd262144;
      5'd13: return 36'sd131072;
      5'd14: return 36'sd65536;
      5'd15: return 36'sd32768;
      5'd16: return 36'sd16384;
      5'd17: return 36'sd8192;
      5'd18: return 36'sd4096;
      5'd19: return 36'sd2048;
      5'd20: return 36'sd1024;
      5'd21: return 36'sd512;
      5'd22: return 36'sd256;
      5'd23: return 36'sd128;
      5'd24: return 36'sd64;
      5'd25: return 36'sd32;
      5'd26: return 36'sd16;
      5'd27: return 36'sd8;
      5'd28: return 36'sd4;
      5'd29: return 36'sd2;
      5'd30: return 36'sd1;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [31:0] clip32(input aopt_wide_t v);
    if (v > MAX32) return 32'sh7fffffff;
    if (v < MIN32) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic clip_hit(input aopt_wide_t v);
    return (v > MAX32) || (v < MIN32);
  endfunction

endpackage

>>> hw/rtl/aopt_if.sv
// Valid/ready channel interfaces for the pose tracker input and result streams.
interface aopt_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] forward_angle;
  logic signed [31:0] side_angle;
  logic signed [31:0] imu_heading;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_heading;

  modport source(output valid, command, forward_angle, side_angle, imu_heading,
                 new_x, new_y, new_heading, input ready);
  modport sink(input valid, command, forward_angle, side_angle, imu_heading,
               new_x, new_y, new_heading, output ready);
endinterface

interface aopt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic               saturated;

  modport source(output valid, pos_x, pos_y, heading, saturated, input ready);
  modport sink(input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface

>>> hw/rtl/aopt_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module aopt_mul import aopt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  aopt_op_t   a,
  input  aopt_op_t   b,
  output logic       busy,
  output logic       done,
  output aopt_prod_t p
);
  localparam int CNT_W = $clog2(OP_W + 1);

  logic [OP_W-1:0]  mcand;
  logic [OP_W-1:0]  hi;
  logic [OP_W-1:0]  lo;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [OP_W:0]    sum;
  logic [PROD_W-1:0] fin;

  always_comb begin
    sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
    fin = {sum, lo[OP_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        mcand <= a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
        lo    <= b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
        hi    <= '0;
        neg   <= a[OP_W-1] ^ b[OP_W-1];
        cnt   <= '0;
      end else if (busy) begin
        {hi, lo} <= fin;
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(OP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          p    <= neg ? aopt_prod_t'(-fin) : aopt_prod_t'(fin);
        end
      end
    end
  end
endmodule

>>> hw/rtl/aopt_div.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module aopt_div import aopt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [OP_W-1:0] num,
  input  logic [OP_W-1:0] den,
  output logic            busy,
  output logic            done,
  output logic [OP_W-1:0] quo,
  output logic [OP_W-1:0] rmd
);
  localparam int CNT_W = $clog2(OP_W + 1);

  logic [OP_W-1:0]  q;
  logic [OP_W-1:0]  rem;
  logic [OP_W-1:0]  dv;
  logic [CNT_W-1:0] cnt;
  logic [OP_W:0]    t;
  logic [OP_W:0]    diff;
  logic             ge;
  logic [OP_W-1:0]  rem_next;
  logic [OP_W-1:0]  q_next;

  always_comb begin
    t        = {rem, q[OP_W-1]};
    diff     = t - {1'b0, dv};
    ge       = (t >= {1'b0, dv});
    rem_next = ge ? diff[OP_W-1:0] : t[OP_W-1:0];
    q_next   = {q[OP_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        q    <= num;
        dv   <= den;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        q   <= q_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(OP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= q_next;
          rmd  <= rem_next;
        end
      end
    end
  end
endmodule

>>> hw/rtl/aopt_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module aopt_cordic import aopt_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  aopt_cw_t z0,
  output logic     busy,
  output logic     done,
  output aopt_cw_t x,
  output aopt_cw_t y,
  output aopt_cw_t z
);
  localparam int SW = $clog2(STEPS + 1);

  logic [SW-1:0] cnt;
  aopt_cw_t      xs;
  aopt_cw_t      ys;
  aopt_cw_t      at;

  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = atan_q30(5'(cnt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= z0;
        cnt  <= '0;
      end else if (busy) begin
        if (!z[CW-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == SW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hw/rtl/arc_odometry_pose_tracker_core.sv
// Top level of the arc odometry pose tracker: sequencer, shared serial units, pose state.
// A set-pose transaction loads the pose and goes straight to the result register.
// A sample runs through the sequencer: up to 17 bit-serial multiplies and 3 bit-serial divides,
// plus 1 or 2 CORDIC passes (1 when the heading does not change). One item is in work at a time.
// Reset (rst, synchronous): pose, sensor history and registers go to their defaults.
`include "arc_odometry_pose_tracker_core_assert.svh"
module arc_odometry_pose_tracker_core import aopt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  aopt_in_if.sink          in_ch,
  aopt_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_FWD_RAD, ST_FWD_DIST, ST_SIDE_RAD, ST_SIDE_DIST, ST_TH,
    ST_SC_MOD, ST_SC_ROT, ST_SC_CX, ST_SC_CY, ST_S_DIV,
    ST_DX_A, ST_DX_B, ST_DY_A, ST_DY_B,
    ST_GX_A, ST_GX_B, ST_GY_A, ST_GY_B, ST_ACC, ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0]        wheel_radius;
  logic signed [CFG_W-1:0] lateral_offset;
  logic signed [CFG_W-1:0] longitudinal_offset;

  // architectural state
  logic signed [47:0] prev_fwd;
  logic signed [47:0] prev_side;
  logic signed [31:0] prev_imu;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;

  // per-transaction working registers
  logic signed [31:0] fa;
  logic signed [31:0] sa;
  logic signed [31:0] ia;
  aopt_op_t           rad;
  logic signed [31:0] dfw;
  logic signed [31:0] dsd;
  logic signed [31:0] dth;
  aopt_cw_t           sh;
  aopt_op_t           s_fac;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  aopt_cw_t           sm;
  aopt_cw_t           cm;
  aopt_cw_t           xc;
  aopt_wide_t         tmp;
  aopt_wide_t         gx;
  aopt_wide_t         gy;
  logic signed [33:0] ang;      // Q.17 angle fed to sin/cos
  logic               sc_pass;  // 0: half heading step, 1: mid heading
  logic               flip;
  aopt_cw_t           z0;
  logic               sat;
  logic               op_wait;

  // result register
  logic               out_valid;
  logic signed [31:0] o_x;
  logic signed [31:0] o_y;
  logic signed [31:0] o_h;
  logic               o_sat;

  // shared units
  logic            mul_go, mul_busy, mul_done;
  aopt_op_t        mul_a, mul_b;
  aopt_prod_t      mul_p;
  logic            div_go, div_busy, div_done;
  logic [OP_W-1:0] div_num, div_den, div_q, div_r;
  logic            cor_go, cor_busy, cor_done;
  aopt_cw_t        cor_x, cor_y, cor_z;

  aopt_mul u_mul (
    .clk, .rst, .go(mul_go), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .p(mul_p)
  );

  aopt_div u_div (
    .clk, .rst, .go(div_go), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_q), .rmd(div_r)
  );

  aopt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .go(cor_go), .z0(z0),
    .busy(cor_busy), .done(cor_done), .x(cor_x), .y(cor_y), .z(cor_z)
  );

  // product post-processing
  aopt_prod_t         p_r16;   // round half up, then >> 16
  aopt_prod_t         p_s16;
  aopt_prod_t         p_s30;
  logic signed [47:0] fd_new;
  logic signed [31:0] dist_delta;
  logic signed [31:0] dth_new;
  logic signed [32:0] imu_diff;
  logic signed [33:0] mid_ang;
  aopt_op_t           sh8;
  aopt_op_t           s_quo;
  aopt_wide_t         sum_x, sum_y, sum_h;

  // modulo 2pi, wrap to (-pi, pi], fold to [-pi/2, pi/2]
  aopt_ang_t r0, r1, r2, r3;
  logic      fold;

  logic is_mul, is_div;

  always_comb begin
    p_r16      = (mul_p + aopt_prod_t'(32768)) >>> 16;
    p_s16      = mul_p >>> 16;
    p_s30      = mul_p >>> 30;
    fd_new     = p_r16[47:0];
    dist_delta = clip32(aopt_wide_t'(fd_new) -
                        aopt_wide_t'((state == ST_FWD_DIST) ? prev_fwd : prev_side));
    dth_new    = clip32(aopt_wide_t'(p_r16));
    imu_diff   = 33'(ia) - 33'(prev_imu);
    mid_ang    = (34'(pose_heading) <<< 1) + 34'(dth);
    sh8        = aopt_op_t'(sh) <<< 3;
    s_quo      = (sh[CW-1] ^ dth[31]) ? aopt_op_t'(-div_q) : aopt_op_t'(div_q);
    sum_x      = aopt_wide_t'(pose_x) + gx;
    sum_y      = aopt_wide_t'(pose_y) + gy;
    sum_h      = aopt_wide_t'(pose_heading) + aopt_wide_t'(dth);

    r0 = aopt_ang_t'({1'b0, div_r[19:0]});
    if (ang[33]) r0 = -r0;
    r1 = r0[ANG_W-1] ? r0 + TWO_PI_Q17 : r0;
    r2 = (r1 > PI_Q17) ? r1 - TWO_PI_Q17 : r1;
    fold = 1'b0;
    r3 = r2;
    if (r2 > HALF_PI_Q17) begin
      r3   = PI_Q17 - r2;
      fold = 1'b1;
    end else if (r2 < -HALF_PI_Q17) begin
      r3   = -PI_Q17 - r2;
      fold = 1'b1;
    end
  end

  // operand selection for the shared units
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    case (state)
      ST_FWD_RAD:  begin mul_a = aopt_op_t'(fa);  mul_b = DEG2RAD_Q32; end
      ST_SIDE_RAD: begin mul_a = aopt_op_t'(sa);  mul_b = DEG2RAD_Q32; end
      ST_FWD_DIST,
      ST_SIDE_DIST: begin
        mul_a = rad;
        mul_b = aopt_op_t'({1'b0, wheel_radius});
      end
      ST_TH:    begin mul_a = aopt_op_t'(imu_diff); mul_b = DEG2RAD_Q32; end
      ST_SC_CX: begin mul_a = aopt_op_t'(cor_y); mul_b = aopt_op_t'(cor_z); end
      ST_SC_CY: begin mul_a = aopt_op_t'(cor_x); mul_b = aopt_op_t'(cor_z); end
      ST_DX_A:  begin mul_a = aopt_op_t'(dsd); mul_b = s_fac; end
      ST_DX_B:  begin
        mul_a = aopt_op_t'(longitudinal_offset) <<< 1;
        mul_b = aopt_op_t'(sh);
      end
      ST_DY_A:  begin mul_a = aopt_op_t'(dfw); mul_b = s_fac; end
      ST_DY_B:  begin
        mul_a = aopt_op_t'(lateral_offset) <<< 1;
        mul_b = aopt_op_t'(sh);
      end
      ST_GX_A:  begin mul_a = aopt_op_t'(dx); mul_b = aopt_op_t'(sm); end
      ST_GX_B:  begin mul_a = aopt_op_t'(dy); mul_b = aopt_op_t'(cm); end
      ST_GY_A:  begin mul_a = aopt_op_t'(dy); mul_b = aopt_op_t'(sm); end
      ST_GY_B:  begin mul_a = aopt_op_t'(dx); mul_b = aopt_op_t'(cm); end
      ST_SC_MOD: begin
        div_num = ang[33] ? OP_W'(-ang) : OP_W'(ang);
        div_den = OP_W'(TWO_PI_Q17);
      end
      ST_S_DIV: begin
        div_num = sh8[OP_W-1] ? OP_W'(-sh8) : OP_W'(sh8);
        div_den = dth[31] ? OP_W'(-dth) : OP_W'(dth);
      end
      default: ;
    endcase
  end

  assign is_div = (state == ST_SC_MOD) || (state == ST_S_DIV);
  assign is_mul = (state == ST_FWD_RAD) || (state == ST_FWD_DIST) ||
                  (state == ST_SIDE_RAD) || (state == ST_SIDE_DIST) ||
                  (state == ST_TH) || (state == ST_SC_CX) || (state == ST_SC_CY) ||
                  (state == ST_DX_A) || (state == ST_DX_B) ||
                  (state == ST_DY_A) || (state == ST_DY_B) ||
                  (state == ST_GX_A) || (state == ST_GX_B) ||
                  (state == ST_GY_A) || (state == ST_GY_B);

  // each op state launches its unit once, then waits for done
  assign mul_go = is_mul && !op_wait;
  assign div_go = is_div && !op_wait;
  assign cor_go = (state == ST_SC_ROT) && !op_wait;

  assign in_ch.ready      = (state == ST_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.pos_x     = o_x;
  assign out_ch.pos_y     = o_y;
  assign out_ch.heading   = o_h;
  assign out_ch.saturated = o_sat;

  // configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius        <= WHEEL_RADIUS_RST;
      lateral_offset      <= '0;
      longitudinal_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEEL_RADIUS:        wheel_radius        <= cfg_data;
        REG_LATERAL_OFFSET:      lateral_offset      <= cfg_data;
        REG_LONGITUDINAL_OFFSET: longitudinal_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op_wait      <= 1'b0;
      out_valid    <= 1'b0;
      prev_fwd     <= '0;
      prev_side    <= '0;
      prev_imu     <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (mul_go || div_go || cor_go) op_wait <= 1'b1;

      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            fa <= in_ch.forward_angle;
            sa <= in_ch.side_angle;
            ia <= in_ch.imu_heading;
            if (in_ch.command == CMD_SET_POSE) begin
              pose_x       <= in_ch.new_x;
              pose_y       <= in_ch.new_y;
              pose_heading <= in_ch.new_heading;
              sat          <= 1'b0;
              state        <= ST_DONE;
            end else begin
              state <= ST_FWD_RAD;
            end
          end
        end
        ST_FWD_RAD, ST_SIDE_RAD: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            rad     <= aopt_op_t'(p_r16);
            state   <= (state == ST_FWD_RAD) ? ST_FWD_DIST : ST_SIDE_DIST;
          end
        end
        ST_FWD_DIST: begin
          if (mul_done) begin
            op_wait  <= 1'b0;
            dfw      <= dist_delta;
            prev_fwd <= fd_new;
            state    <= ST_SIDE_RAD;
          end
        end
        ST_SIDE_DIST: begin
          if (mul_done) begin
            op_wait   <= 1'b0;
            dsd       <= dist_delta;
            prev_side <= fd_new;
            state     <= ST_TH;
          end
        end
        ST_TH: begin
          if (mul_done) begin
            op_wait  <= 1'b0;
            dth      <= dth_new;
            prev_imu <= ia;
            if (dth_new == '0) begin
              // straight-line branch: no sine needed
              sh    <= '0;
              s_fac <= aopt_op_t'(65536);
              state <= ST_DX_A;
            end else begin
              ang     <= 34'(dth_new);
              sc_pass <= 1'b0;
              state   <= ST_SC_MOD;
            end
          end
        end
        ST_SC_MOD: begin
          if (div_done) begin
            op_wait <= 1'b0;
            z0      <= aopt_cw_t'(r3) <<< 13;
            flip    <= fold;
            state   <= ST_SC_ROT;
          end
        end
        ST_SC_ROT: begin
          if (cor_done) begin
            op_wait <= 1'b0;
            state   <= ST_SC_CX;
          end
        end
        ST_SC_CX: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            xc      <= cor_x - aopt_cw_t'(p_s30);
            state   <= ST_SC_CY;
          end
        end
        ST_SC_CY: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            if (!sc_pass) begin
              sh    <= cor_y + aopt_cw_t'(p_s30);
              state <= ST_S_DIV;
            end else begin
              sm    <= cor_y + aopt_cw_t'(p_s30);
              cm    <= flip ? -xc : xc;
              state <= ST_GX_A;
            end
          end
        end
        ST_S_DIV: begin
          if (div_done) begin
            op_wait <= 1'b0;
            s_fac   <= s_quo;
            state   <= ST_DX_A;
          end
        end
        ST_DX_A, ST_DY_A: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            tmp     <= aopt_wide_t'(p_s16);
            state   <= (state == ST_DX_A) ? ST_DX_B : ST_DY_B;
          end
        end
        ST_DX_B: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            dx      <= clip32(tmp - aopt_wide_t'(p_s30));
            state   <= ST_DY_A;
          end
        end
        ST_DY_B: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            dy      <= clip32(tmp - aopt_wide_t'(p_s30));
            ang     <= mid_ang;
            sc_pass <= 1'b1;
            state   <= ST_SC_MOD;
          end
        end
        ST_GX_A, ST_GY_A: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            tmp     <= aopt_wide_t'(mul_p);
            state   <= (state == ST_GX_A) ? ST_GX_B : ST_GY_B;
          end
        end
        ST_GX_B: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            gx      <= (tmp + aopt_wide_t'(mul_p)) >>> 30;
            state   <= ST_GY_A;
          end
        end
        ST_GY_B: begin
          if (mul_done) begin
            op_wait <= 1'b0;
            gy      <= (tmp - aopt_wide_t'(mul_p)) >>> 30;
            state   <= ST_ACC;
          end
        end
        ST_ACC: begin
          pose_x       <= clip32(sum_x);
          pose_y       <= clip32(sum_y);
          pose_heading <= clip32(sum_h);
          sat          <= clip_hit(sum_x) || clip_hit(sum_y) || clip_hit(sum_h);
          state        <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            o_x       <= pose_x;
            o_y       <= pose_y;
            o_h       <= pose_heading;
            o_sat     <= sat;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `AOPT_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, state != ST_IDLE, "accepted transaction did not start work")
  `AOPT_ASSERT_IMPLY(a_mul_free, mul_go, !mul_busy, "multiplier launched while busy")
  `AOPT_ASSERT_IMPLY(a_div_free, div_go, !div_busy, "divider launched while busy")
  `AOPT_ASSERT_IMPLY(a_one_unit, 1'b1, $countones({mul_busy, div_busy, cor_busy}) <= 1, "two serial units active at once")

endmodule

>>> tb/sv/arc_odometry_pose_tracker_core_test.sv
// Self-checking testbench for the arc odometry pose tracker core.
`timescale 1ns / 100ps

module arc_odometry_pose_tracker_core_test;
  import aopt_pkg::*;

  // Watchdog limit: cycles with no transaction on either channel.
  // The limit sits well above both a slow sample and the long sink hold-off.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;  // no register here; writes ignored

  typedef struct packed {
    logic               command;
    logic signed [31:0] forward_angle;
    logic signed [31:0] side_angle;
    logic signed [31:0] imu_heading;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading;
  } odo_txn_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic               saturated;
  } pose_t;

  // Pose tracker scoreboard: own copy of registers, sensor history and pose,
  // plus the queue of poses that the block still owes us.
  class pose_scoreboard;
    logic [23:0]        radius;
    logic signed [23:0] lat_off;
    logic signed [23:0] long_off;
    longint             last_fwd_dist, last_side_dist, last_imu;
    logic signed [31:0] px, py, ph;
    pose_t              owed[$];
    longint             atan_tbl[16] = '{843314857, 497837829, 263043837, 133525159,
                                         67021687, 33543516, 16775851, 8388437,
                                         4194283, 2097149, 1048576, 524288, 262144,
                                         131072, 65536, 32768};

    function new();
      radius = WHEEL_RADIUS_RST;
      lat_off = '0;
      long_off = '0;
      last_fwd_dist = 0;
      last_side_dist = 0;
      last_imu = 0;
      px = '0;
      py = '0;
      ph = '0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_WHEEL_RADIUS:        radius = data;
        REG_LATERAL_OFFSET:      lat_off = data;
        REG_LONGITUDINAL_OFFSET: long_off = data;
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clip32(longint v, inout bit hit);
      if (v > 64'sd2147483647) begin
        hit = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        hit = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint centideg_to_dist(longint c);
      longint rad;
      rad = round_shift(c * 749613, 16);
      return round_shift(rad * longint'({40'd0, radius}), 16);
    endfunction

    // angle in Q.17 radians in, Q2.30 sine/cosine out
    function void sin_cos(longint a, output longint sn, output longint cs);
      longint r, x, y, z, xs, ys;
      bit flip;
      r = a % 823550;
      flip = 0;
      if (r < 0) r += 823550;
      if (r > 411775) r -= 823550;
      if (r > 205887) begin
        r = 411775 - r;
        flip = 1;
      end else if (r < -205887) begin
        r = -411775 - r;
        flip = 1;
      end
      z = r * 8192;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tbl[i];
        end else begin
          x += ys; y -= xs; z += atan_tbl[i];
        end
      end
      sn = y + ((x * z) >>> 30);
      cs = x - ((y * z) >>> 30);
      if (flip) cs = -cs;
    endfunction

    function void note_input(odo_txn_t t);
      pose_t  p;
      bit     junk, sat;
      longint fd, sd, dfw, dsd, dth, sh, ch, s_fac, dx, dy, sm, cm, gx, gy;
      junk = 0;
      sat = 0;
      if (t.command == CMD_SET_POSE) begin
        px = t.new_x;
        py = t.new_y;
        ph = t.new_heading;
      end else begin
        fd = centideg_to_dist(longint'(t.forward_angle));
        sd = centideg_to_dist(longint'(t.side_angle));
        dfw = clip32(fd - last_fwd_dist, junk);
        dsd = clip32(sd - last_side_dist, junk);
        dth = clip32(round_shift((longint'(t.imu_heading) - last_imu) * 749613, 16), junk);
        last_fwd_dist = fd;
        last_side_dist = sd;
        last_imu = t.imu_heading;
        sh = 0;
        s_fac = 65536;
        if (dth != 0) begin
          sin_cos(dth, sh, ch);
          s_fac = (sh * 8) / dth;
        end
        dx = clip32(((dsd * s_fac) >>> 16) - ((2 * longint'(long_off) * sh) >>> 30), junk);
        dy = clip32(((dfw * s_fac) >>> 16) - ((2 * longint'(lat_off) * sh) >>> 30), junk);
        sin_cos(2 * longint'(ph) + dth, sm, cm);
        gx = (dx * sm + dy * cm) >>> 30;
        gy = (dy * sm - dx * cm) >>> 30;
        px = clip32(longint'(px) + gx, sat);
        py = clip32(longint'(py) + gy, sat);
        ph = clip32(longint'(ph) + dth, sat);
      end
      p.pos_x = px;
      p.pos_y = py;
      p.heading = ph;
      p.saturated = sat;
      owed.push_back(p);
    endfunction

    // Returns an empty string on a match, else a description of the mismatch.
    function string check_result(pose_t got);
      pose_t e;
      if (owed.size() == 0) return $sformatf("unexpected result x=%0d", got.pos_x);
      e = owed.pop_front();
      if (got !== e)
        return $sformatf("x %0d/%0d y %0d/%0d hdg %0d/%0d sat %0b/%0b (got/exp)",
                         got.pos_x, e.pos_x, got.pos_y, e.pos_y,
                         got.heading, e.heading, got.saturated, e.saturated);
      return "";
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  aopt_in_if  in_ch();
  aopt_out_if out_ch();

  arc_odometry_pose_tracker_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  pose_scoreboard sb = new();
  int  mismatches = 0;
  int  hold_cycles = 0;   // sink hold-off request, counted down by the sink process
  bit  no_idle = 0;       // phase with both sides always willing
  int  sink_stall = 0;
  int  quiet_cycles = 0;
  logic signed [31:0] cur_fwd = 0, cur_side = 0, cur_imu = 0;

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Mostly zero, some short, a few long gaps.
  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Result side: check on every transaction, then decide next cycle's ready.
  always @(posedge clk) begin
    string msg;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        msg = sb.check_result({out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.saturated});
        if (msg != "") report(msg);
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (sink_stall > 0) begin
        out_ch.ready <= 1'b0;
        sink_stall--;
      end else begin
        sink_stall = pick_gap();
        out_ch.ready <= (sink_stall == 0);
      end
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("arc_odometry_pose_tracker_core regression: fail");
      $finish;
    end
  end

  // Drive one transaction, hold it until accepted, then idle for a gap.
  // valid is only lowered when a gap follows or the burst ends.
  task send(odo_txn_t t, bit last);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.command       <= t.command;
    in_ch.forward_angle <= t.forward_angle;
    in_ch.side_angle    <= t.side_angle;
    in_ch.imu_heading   <= t.imu_heading;
    in_ch.new_x         <= t.new_x;
    in_ch.new_y         <= t.new_y;
    in_ch.new_heading   <= t.new_heading;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(t);
    gap = pick_gap();
    if (last || gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_regs(logic [CFG_W-1:0] radius, logic [CFG_W-1:0] lat, logic [CFG_W-1:0] lng);
    cfg_we <= 1'b1;
    cfg_index <= REG_WHEEL_RADIUS;        cfg_data <= radius; @(posedge clk);
    cfg_index <= REG_LATERAL_OFFSET;      cfg_data <= lat;    @(posedge clk);
    cfg_index <= REG_LONGITUDINAL_OFFSET; cfg_data <= lng;    @(posedge clk);
    // out-of-range index must change nothing
    cfg_index <= REG_UNUSED;              cfg_data <= $urandom; @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_WHEEL_RADIUS, radius);
    sb.write_reg(REG_LATERAL_OFFSET, lat);
    sb.write_reg(REG_LONGITUDINAL_OFFSET, lng);
    @(posedge clk);
  endtask

  function odo_txn_t make_sample(logic signed [31:0] f, logic signed [31:0] s,
                                 logic signed [31:0] h);
    odo_txn_t t;
    t.command = CMD_SAMPLE;
    t.forward_angle = f;
    t.side_angle = s;
    t.imu_heading = h;
    t.new_x = $urandom;     // ignored by samples, toggled anyway
    t.new_y = $urandom;
    t.new_heading = $urandom;
    cur_fwd = f;
    cur_side = s;
    cur_imu = h;
    return t;
  endfunction

  function odo_txn_t make_set(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] h);
    odo_txn_t t;
    t.command = CMD_SET_POSE;
    t.forward_angle = $urandom;
    t.side_angle = $urandom;
    t.imu_heading = $urandom;
    t.new_x = x;
    t.new_y = y;
    t.new_heading = h;
    return t;
  endfunction

  function logic signed [31:0] small_step(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random traffic: mostly a robot driving around, some pose loads,
  // some wild sensor jumps and near-limit poses to push saturation.
  function odo_txn_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      return make_set($urandom, $urandom, $urandom);
    if (r < 18)
      return make_set(32'sh7fff0000 + small_step(30000), 32'sh80010000 + small_step(30000),
                      ($urandom_range(0, 1) ? 32'sh7ffff000 : 32'sh80001000));
    if (r < 26)
      return make_sample($urandom, $urandom, $urandom);
    if (r < 34)
      return make_sample(cur_fwd + small_step(2000), cur_side + small_step(2000), cur_imu);
    return make_sample(cur_fwd + small_step(3000), cur_side + small_step(1500),
                       cur_imu + small_step(4000));
  endfunction

  task run_random(int n);
    for (int i = 0; i < n; i++) send(random_item(), i == n - 1);
  endtask

  initial begin
    odo_txn_t dir_q[$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_WHEEL_RADIUS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_SAMPLE;
    in_ch.forward_angle = '0;
    in_ch.side_angle = '0;
    in_ch.imu_heading = '0;
    in_ch.new_x = '0;
    in_ch.new_y = '0;
    in_ch.new_heading = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pose loads at the extremes, zero motion (straight-line branch),
    // sensor jumps that clip, heading and position saturation, and history
    // surviving a pose load.
    dir_q.push_back(make_sample(0, 0, 0));
    dir_q.push_back(make_sample(1000, 0, 0));
    dir_q.push_back(make_sample(1000, 500, 0));
    dir_q.push_back(make_sample(3000, 700, 1500));
    dir_q.push_back(make_set(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    dir_q.push_back(make_set(32'sh80000000, 32'sh7fffffff, 32'sh80000000));
    dir_q.push_back(make_set(0, 0, 0));
    dir_q.push_back(make_sample(3000, 700, 1500));
    dir_q.push_back(make_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    dir_q.push_back(make_sample(32'sh80000000, 32'sh80000000, 32'sh80000000));
    dir_q.push_back(make_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    dir_q.push_back(make_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    dir_q.push_back(make_set(32'sh7ffff000, 32'sh7ffff000, 32'sh7ffff000));
    dir_q.push_back(make_sample(32'sh7fffffff + 0, 32'sh80000000 + 5000, 32'sh7fffffff));
    dir_q.push_back(make_sample(32'sh80000000 + 9000, 32'sh80000000 + 9000, 32'sh80000000 + 900));
    dir_q.push_back(make_set(32'sh80000800, 32'sh80000800, 32'sh80000800));
    dir_q.push_back(make_sample(32'sh80000000, 32'sh80000000, 32'sh80000000));
    dir_q.push_back(make_sample(32'sh80000000 + 1, 32'sh80000000 + 1, 32'sh80000000 + 1));
    dir_q.push_back(make_set(0, 0, 32'sh00032000));
    dir_q.push_back(make_sample(0, 0, 0));
    foreach (dir_q[i]) send(dir_q[i], i == dir_q.size() - 1);
    drain();

    // Offsets at their extremes, largest wheel.
    write_regs(24'hffffff, 24'h7fffff, 24'h800000);
    send(make_sample(0, 0, 1000), 0);
    send(make_sample(500, 500, -3000), 0);
    run_random(120);
    drain();

    // Zero radius: after the first sample only the offset terms move the position.
    write_regs(24'h000000, 24'h800000, 24'h7fffff);
    run_random(80);
    // sender pauses until the block has returned everything
    drain();
    run_random(40);
    drain();

    // No idling on either side.
    write_regs($urandom_range(1, 24'h3ffff), $urandom, $urandom);
    no_idle = 1;
    run_random(120);
    drain();
    no_idle = 0;

    // Long sink hold-off while the source keeps offering.
    write_regs(WHEEL_RADIUS_RST, 24'h010000, 24'hff0000);
    hold_cycles = HOLD_OFF_CYCLES;
    run_random(40);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_regs($urandom, $urandom, $urandom);
      run_random(60);
      drain();
    end

    if (mismatches == 0 && sb.pending() == 0) begin
      $display("arc_odometry_pose_tracker_core regression: pass");
    end else begin
      $display("arc_odometry_pose_tracker_core regression: fail");
    end
    $finish;
  end

endmodule
